// ----- hdl/upi_pkg.sv -----
// Shared types and constants for the unicycle pose integrator.
`default_nettype none

package upi_pkg;

    localparam int unsigned CORDIC_ITERATIONS_DEF = 16;
    localparam int unsigned ATAN_DEPTH            = 24;
    localparam int unsigned ATAN_IDX_W            = 5;

    localparam logic [15:0] TIME_STEP_RESET = 16'd1311;
    localparam logic [15:0] HEADING_RESET   = 16'd57344;
    localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_ROUND,
        S_MUL_XC,
        S_MUL_XT,
        S_MUL_YS,
        S_MUL_YT,
        S_MUL_H,
        S_HEAD,
        S_OUT
    } t_state;

    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/unicycle_pose_integrator.sv -----
// Unicycle pose integrator: CORDIC heading rotation and shared multiplier under one sequencer.
//
//   Channel   Dir  Handshake                     Payload (low bit first)
//   s_axis    in   s_axis_tvalid/s_axis_tready   speed[15:0], turn_rate[39:16]
//   m_axis    out  m_axis_tvalid/m_axis_tready   pos_x[31:0], pos_y[63:32], heading[79:64]
//   cfg       in   i_cfg_valid/o_cfg_ready       time_step[15:0]
//
// A request steps from acceptance through the CORDIC, rounding, multiply, heading and output states:
// one CORDIC micro-rotation per cycle, then five passes through the single 32x17 multiplier.
// The block takes no new request until the result is loaded into the output register.
// A result that is not taken holds the sequencer in its final state.
// Reset is synchronous and active low; the pose resets to the origin, heading 57344.
`default_nettype none

module unicycle_pose_integrator
    import upi_pkg::*;
#(
    parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // speed[15:0], turn_rate[39:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data      // time_step[15:0]
);

    localparam int unsigned CNT_W = $clog2(CORDIC_ITERATIONS);
    localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_ITERATIONS - 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_iter, n_iter;
    logic signed [33:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic               r_flip, n_flip;
    logic signed [15:0] r_cos, n_cos, r_sin, n_sin;
    logic signed [15:0] r_speed, n_speed;
    logic signed [23:0] r_rate, n_rate;
    logic signed [48:0] r_prod, n_prod;
    logic signed [31:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [15:0]        r_heading, n_heading;
    logic [15:0]        r_dt, n_dt;
    logic               r_out_valid, n_out_valid;
    logic [79:0]        r_out_data, n_out_data;

    logic signed [31:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [48:0] w_prod;
    logic signed [48:0] w_prod_rnd;
    logic signed [25:0] w_delta;
    logic signed [31:0] w_pos_sel;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_pos_sat;
    logic signed [33:0] w_x_sh, w_y_sh;
    logic signed [33:0] w_atan;
    logic signed [15:0] w_hs;
    logic signed [33:0] w_z0;
    logic [15:0]        w_dh;

    function automatic logic signed [15:0] round_q15(input logic signed [33:0] v,
                                                     input logic flip);
        logic signed [33:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (flip) begin
            t = -t;
        end
        if (t > 34'sd32767) begin
            return 16'sh7FFF;
        end else if (t < -34'sd32768) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_rnd = r_prod + 49'sd4194304;
    assign w_delta    = w_prod_rnd[48:23];
    assign w_pos_sel  = (r_state == S_MUL_YS) ? r_pos_x : r_pos_y;
    assign w_sum      = {w_pos_sel[31], w_pos_sel} + {{7{w_delta[25]}}, w_delta};
    assign w_pos_sat  = (w_sum[32] != w_sum[31]) ?
                        (w_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : w_sum[31:0];
    assign w_dh       = 16'(r_prod + 49'sd32768 >>> 16);

    assign w_x_sh = r_cx >>> r_iter;
    assign w_y_sh = r_cy >>> r_iter;
    assign w_atan = {2'b00, atan_turn(ATAN_IDX_W'(r_iter))};

    assign w_hs = r_heading;
    assign w_z0 = {{2{w_hs[15]}}, w_hs, 16'h0000};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL_XC: begin
                w_mul_a = 32'(r_speed);
                w_mul_b = 17'(r_cos);
            end
            S_MUL_YS: begin
                w_mul_a = 32'(r_speed);
                w_mul_b = 17'(r_sin);
            end
            S_MUL_XT, S_MUL_YT: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = {1'b0, r_dt};
            end
            S_MUL_H: begin
                w_mul_a = 32'(r_rate);
                w_mul_b = {1'b0, r_dt};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_flip      = r_flip;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_speed     = r_speed;
        n_rate      = r_rate;
        n_prod      = r_prod;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_dt        = r_dt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (i_cfg_valid) begin
            n_dt = i_cfg_data;
        end
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_speed = s_axis_tdata[15:0];
                    n_rate  = s_axis_tdata[39:16];
                    n_cx    = CORDIC_GAIN_Q30;
                    n_cy    = '0;
                    n_iter  = '0;
                    if (w_hs > 16'sd16384) begin
                        n_cz   = w_z0 - 34'sh080000000;
                        n_flip = 1'b1;
                    end else if (w_hs < -16'sd16384) begin
                        n_cz   = w_z0 + 34'sh080000000;
                        n_flip = 1'b1;
                    end else begin
                        n_cz   = w_z0;
                        n_flip = 1'b0;
                    end
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (!r_cz[33]) begin
                    n_cx = r_cx - w_y_sh;
                    n_cy = r_cy + w_x_sh;
                    n_cz = r_cz - w_atan;
                end else begin
                    n_cx = r_cx + w_y_sh;
                    n_cy = r_cy - w_x_sh;
                    n_cz = r_cz + w_atan;
                end
                if (r_iter == LAST_ITER) begin
                    n_state = S_ROUND;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_ROUND: begin
                n_cos   = round_q15(r_cx, r_flip);
                n_sin   = round_q15(r_cy, r_flip);
                n_state = S_MUL_XC;
            end
            S_MUL_XC: begin
                n_prod  = w_prod;
                n_state = S_MUL_XT;
            end
            S_MUL_XT: begin
                n_prod  = w_prod;
                n_state = S_MUL_YS;
            end
            S_MUL_YS: begin
                n_pos_x = w_pos_sat;
                n_prod  = w_prod;
                n_state = S_MUL_YT;
            end
            S_MUL_YT: begin
                n_prod  = w_prod;
                n_state = S_MUL_H;
            end
            S_MUL_H: begin
                n_pos_y = w_pos_sat;
                n_prod  = w_prod;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_heading = r_heading + w_dh;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_heading, r_pos_y, r_pos_x};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= HEADING_RESET;
            r_dt        <= TIME_STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_dt        <= n_dt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter     <= n_iter;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cz       <= n_cz;
        r_flip     <= n_flip;
        r_cos      <= n_cos;
        r_sin      <= n_sin;
        r_speed    <= n_speed;
        r_rate     <= n_rate;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

    a_accept_starts_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CORDIC && r_iter == '0))
        else $error("accepted request did not start the rotation sequence");

    a_heading_only_in_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_HEAD) |=> $stable(r_heading))
        else $error("heading changed outside its update step");

    a_valid_rises_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT && r_state == S_IDLE))
        else $error("result appeared without finishing the sequence");

    a_pos_x_only_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL_YS) |=> $stable(r_pos_x))
        else $error("x position changed outside its update step");

endmodule

`default_nettype wire
